/* hdl/mbrc_pkg.sv */
`default_nettype none

package mbrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_LSB = 16'h0001;
  localparam logic [8:0] MIN_FRAME_BYTES = 9'd4;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd1;
  localparam logic [7:0] FUNCTION_CODE_RST = 8'd4;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_HDR_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_FUNCTION_CODE  = 2'd1,
    REG_TIMEOUT_TICKS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  function_code;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  status;
    logic [8:0]  bytes_received;
  } res_t;

endpackage

`default_nettype wire

/* hdl/mbrc_crc_byte.sv */
`default_nettype none

module mbrc_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);
  import mbrc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != 16'h0000) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

/* hdl/mbrc_frame_ctrl.sv */
`default_nettype none

module mbrc_frame_ctrl #(
  parameter int unsigned MAX_FRAME_BYTES = mbrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_vld,
  input  wire logic [1:0]      req_opcode,
  input  wire logic [7:0]      req_data_byte,
  input  wire logic [8:0]      req_frame_length,
  input  wire mbrc_pkg::cfg_t  cfg,
  output mbrc_pkg::res_t       res
);
  import mbrc_pkg::*;

  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES);

  logic        frame_active_r, frame_active_nxt;
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [8:0]  expected_length_r, expected_length_nxt;
  logic [16:0] elapsed_ticks_r, elapsed_ticks_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_low_byte_r, crc_low_byte_nxt;
  logic        header_ok_r, header_ok_nxt;

  logic [15:0] crc_upd;
  logic [8:0]  crc_end;
  logic [8:0]  len_clamped;
  logic [16:0] elapsed_inc;
  opcode_t     op;

  mbrc_crc_byte u_crc (
    .crc_in  (running_crc_r),
    .data_in (req_data_byte),
    .crc_out (crc_upd)
  );

  assign op = opcode_t'(req_opcode);
  assign crc_end = expected_length_r - 9'd2;
  assign elapsed_inc = (elapsed_ticks_r < ELAPSED_MAX) ? elapsed_ticks_r + 17'd1
                                                        : elapsed_ticks_r;

  always_comb begin
    if (req_frame_length < MIN_FRAME_BYTES) begin
      len_clamped = MIN_FRAME_BYTES;
    end else if (req_frame_length > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = req_frame_length;
    end
  end

  always_comb begin
    frame_active_nxt    = frame_active_r;
    byte_count_nxt      = byte_count_r;
    expected_length_nxt = expected_length_r;
    elapsed_ticks_nxt   = elapsed_ticks_r;
    running_crc_nxt     = running_crc_r;
    crc_low_byte_nxt    = crc_low_byte_r;
    header_ok_nxt       = header_ok_r;
    res.vld             = 1'b0;
    res.status          = ST_OK;
    res.bytes_received  = byte_count_r;
    if (req_vld) begin
      case (op)
        OP_START: begin
          expected_length_nxt = len_clamped;
          frame_active_nxt    = 1'b1;
          byte_count_nxt      = 9'd0;
          elapsed_ticks_nxt   = 17'd0;
          running_crc_nxt     = CRC_INIT;
          crc_low_byte_nxt    = 8'd0;
          header_ok_nxt       = 1'b1;
        end
        OP_BYTE: begin
          if (frame_active_r) begin
            if ((byte_count_r == 9'd0 && req_data_byte != cfg.device_address) ||
                (byte_count_r == 9'd1 && req_data_byte != cfg.function_code)) begin
              header_ok_nxt = 1'b0;
            end
            byte_count_nxt = byte_count_r + 9'd1;
            if (byte_count_r < crc_end) begin
              running_crc_nxt = crc_upd;
            end else if (byte_count_r == crc_end) begin
              crc_low_byte_nxt = req_data_byte;
            end else begin
              frame_active_nxt   = 1'b0;
              res.vld            = 1'b1;
              res.bytes_received = byte_count_r + 9'd1;
              if ({req_data_byte, crc_low_byte_r} != running_crc_r) begin
                res.status = ST_CRC_ERR;
              end else if (!header_ok_nxt) begin
                res.status = ST_HDR_ERR;
              end else begin
                res.status = ST_OK;
              end
            end
          end
        end
        OP_TICK: begin
          if (frame_active_r) begin
            elapsed_ticks_nxt = elapsed_inc;
            if (elapsed_inc > {1'b0, cfg.timeout_ticks}) begin
              frame_active_nxt = 1'b0;
              res.vld          = 1'b1;
              res.status       = ST_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r    <= 1'b0;
      byte_count_r      <= 9'd0;
      expected_length_r <= MIN_FRAME_BYTES;
      elapsed_ticks_r   <= 17'd0;
      running_crc_r     <= CRC_INIT;
      crc_low_byte_r    <= 8'd0;
      header_ok_r       <= 1'b1;
    end else begin
      frame_active_r    <= frame_active_nxt;
      byte_count_r      <= byte_count_nxt;
      expected_length_r <= expected_length_nxt;
      elapsed_ticks_r   <= elapsed_ticks_nxt;
      running_crc_r     <= running_crc_nxt;
      crc_low_byte_r    <= crc_low_byte_nxt;
      header_ok_r       <= header_ok_nxt;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_active_r |-> (expected_length_r >= MIN_FRAME_BYTES && expected_length_r <= MAX_LEN))
    else $error("expected length out of range");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    frame_active_r |-> byte_count_r < expected_length_r)
    else $error("byte count reached expected length while frame open");

  a_close_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |=> !frame_active_r)
    else $error("frame still open after result");

endmodule

`default_nettype wire

/* hdl/modbus_response_frame_checker.sv */
// A request is registered in the input register when accepted, and its result is registered
// in the output register, where it is held while out_stall is high.
// Throughput: one request per cycle unless stalled by a held result; single-pass update.
// Reset (rst_n, synchronous, active low) closes any frame, empties both registers and
// restores the register defaults: address 1, function 4, timeout 100 ticks.
`default_nettype none

module modbus_response_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = mbrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [8:0]  in_frame_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [8:0]       out_bytes_received,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import mbrc_pkg::*;

  cfg_t        cfg_r;
  logic        in_vld_r;
  logic [1:0]  in_opcode_r;
  logic [7:0]  in_data_byte_r;
  logic [8:0]  in_frame_length_r;
  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [8:0]  out_bytes_r;
  logic        advance;
  res_t        res;

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.function_code  <= FUNCTION_CODE_RST;
      cfg_r.timeout_ticks  <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata[7:0];
        REG_FUNCTION_CODE:  cfg_r.function_code  <= cfg_wdata[7:0];
        REG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_opcode_r       <= in_opcode;
      in_data_byte_r    <= in_data_byte;
      in_frame_length_r <= in_frame_length;
    end
  end

  mbrc_frame_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_vld          (advance),
    .req_opcode       (in_opcode_r),
    .req_data_byte    (in_data_byte_r),
    .req_frame_length (in_frame_length_r),
    .cfg              (cfg_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= advance & res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_status_r <= res.status;
      out_bytes_r  <= res.bytes_received;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_bytes_received = out_bytes_r;

  a_stall_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked request");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !advance)
    else $error("request processed while result is held");

  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r != ST_TIMEOUT) |-> out_bytes_r >= MIN_FRAME_BYTES)
    else $error("completed frame shorter than minimum");

endmodule

`default_nettype wire

/* dv/tb_modbus_response_frame_checker.sv */
`timescale 1ns / 100ps

module tb_modbus_response_frame_checker;
  import mbrc_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [8:0] count;
  } verdict_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_ADDR,
    FRAME_BAD_FUNC,
    FRAME_BAD_CRC,
    FRAME_BAD_ALL,
    FRAME_CUT
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_frame_length;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [8:0]  out_bytes_received;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  verdict_t    pending_verdicts[$];
  verdict_t    head;
  int unsigned error_count;
  int unsigned live_items;
  bit          idle_on;

  logic [7:0]  dev_addr;
  logic [7:0]  func_code;
  logic [15:0] tick_limit;
  bit          frame_open;
  logic [8:0]  rx_count;
  logic [8:0]  frame_len;
  logic [16:0] tick_count;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  bit          hdr_match;

  modbus_response_frame_checker uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_data_byte(in_data_byte),
    .in_frame_length(in_frame_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_bytes_received(out_bytes_received),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_len(logic [8:0] len);
    logic [8:0] eff;
    eff = (len < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : len;
    if (eff > 9'(MAX_FRAME_BYTES_DEF)) begin
      eff = 9'(MAX_FRAME_BYTES_DEF);
    end
    return eff;
  endfunction

  task automatic track_frame(opcode_t op, logic [7:0] d, logic [8:0] len);
    logic [8:0] idx;
    logic [8:0] crc_end;
    verdict_t   v;
    case (op)
      OP_START: begin
        frame_len  = clamp_len(len);
        frame_open = 1'b1;
        rx_count   = '0;
        tick_count = '0;
        crc_acc    = CRC_INIT;
        crc_lo     = '0;
        hdr_match  = 1'b1;
        live_items++;
      end
      OP_BYTE: begin
        if (frame_open) begin
          live_items++;
          idx     = rx_count;
          crc_end = frame_len - 9'd2;
          if (idx == 9'd0 && d != dev_addr) hdr_match = 1'b0;
          if (idx == 9'd1 && d != func_code) hdr_match = 1'b0;
          rx_count = rx_count + 9'd1;
          if (idx < crc_end) begin
            crc_acc = crc16_modbus_byte(crc_acc, d);
          end else if (idx == crc_end) begin
            crc_lo = d;
          end else begin
            if ({d, crc_lo} != crc_acc) v.status = ST_CRC_ERR;
            else if (!hdr_match) v.status = ST_HDR_ERR;
            else v.status = ST_OK;
            v.count    = rx_count;
            frame_open = 1'b0;
            pending_verdicts.push_back(v);
          end
        end
      end
      OP_TICK: begin
        if (frame_open) begin
          live_items++;
          if (tick_count < ELAPSED_MAX) tick_count = tick_count + 17'd1;
          if (tick_count > {1'b0, tick_limit}) begin
            v.status   = ST_TIMEOUT;
            v.count    = rx_count;
            frame_open = 1'b0;
            pending_verdicts.push_back(v);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_req(opcode_t op, logic [7:0] d, logic [8:0] len);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_data_byte    <= d;
    in_frame_length <= len;
    do @(posedge clk); while (in_stall);
    track_frame(op, d, len);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] a, logic [7:0] f, logic [15:0] t);
    logic [7:0] junk;
    drain();
    junk = 8'($urandom_range(0, 255));
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEVICE_ADDRESS;
    cfg_wdata <= {junk, a};
    @(posedge clk);
    junk = 8'($urandom_range(0, 255));
    cfg_index <= REG_FUNCTION_CODE;
    cfg_wdata <= {junk, f};
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    dev_addr   = a;
    func_code  = f;
    tick_limit = t;
  endtask

  task automatic send_frame(logic [8:0] len_field, frame_kind_t kind, int unsigned tick_pct);
    logic [7:0]  body[$];
    logic [7:0]  mask;
    logic [15:0] crc;
    int unsigned eff;
    int unsigned n_send;
    eff  = 32'(clamp_len(len_field));
    mask = 8'h01 << $urandom_range(0, 7);
    for (int i = 0; i < eff - 2; i++) begin
      body.push_back((i == 0) ? dev_addr : (i == 1) ? func_code : 8'($urandom_range(0, 255)));
    end
    if (kind == FRAME_BAD_ADDR || kind == FRAME_BAD_ALL) body[0] = body[0] ^ mask;
    if (kind == FRAME_BAD_FUNC) body[1] = body[1] ^ mask;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc16_modbus_byte(crc, body[i]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (kind == FRAME_BAD_CRC || kind == FRAME_BAD_ALL) begin
      n_send = $urandom_range(eff - 2, eff - 1);
      body[n_send] = body[n_send] ^ (8'h01 << $urandom_range(0, 7));
    end
    n_send = (kind == FRAME_CUT) ? $urandom_range(0, eff - 1) : eff;
    send_req(OP_START, 8'($urandom_range(0, 255)), len_field);
    for (int i = 0; i < n_send; i++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_req(OP_TICK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end
      send_req(OP_BYTE, body[i], 9'($urandom_range(0, 511)));
    end
  endtask

  task automatic test_default_frame();
    send_frame(9'd0, FRAME_GOOD, 0);
    send_frame(9'd3, FRAME_GOOD, 0);
  endtask

  task automatic test_known_crc();
    logic [7:0] msg[$];
    set_config(8'h31, 8'h32, 16'd100);
    msg = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h37, 8'h4B};
    send_req(OP_START, 8'h00, 9'd11);
    foreach (msg[i]) send_req(OP_BYTE, msg[i], 9'h1FF);
  endtask

  task automatic test_header_and_crc();
    set_config(8'h00, 8'hFF, 16'hFFFF);
    send_frame(9'd4, FRAME_BAD_ADDR, 0);
    send_frame(9'd4, FRAME_BAD_FUNC, 0);
    set_config(8'hFF, 8'h00, 16'd100);
    send_frame(9'd4, FRAME_BAD_ALL, 0);
    send_frame(9'd5, FRAME_BAD_CRC, 0);
  endtask

  task automatic test_ignored_requests();
    drain();
    send_req(OP_BYTE, 8'hFF, 9'h1FF);
    send_req(OP_TICK, 8'h00, 9'h000);
    send_req(OP_NONE, 8'hA5, 9'h100);
    send_req(OP_START, 8'h00, 9'd6);
    send_req(OP_BYTE, dev_addr, 9'd0);
    send_req(OP_NONE, 8'h5A, 9'h0FF);
    send_frame(9'd4, FRAME_GOOD, 0);
  endtask

  task automatic test_timeout();
    set_config(8'd1, 8'd4, 16'd0);
    send_req(OP_START, 8'h00, 9'd4);
    send_req(OP_TICK, 8'h00, 9'd0);
    set_config(8'd1, 8'd4, 16'd3);
    send_req(OP_START, 8'h00, 9'd8);
    send_req(OP_BYTE, 8'd1, 9'd0);
    send_req(OP_BYTE, 8'd4, 9'd0);
    repeat (5) send_req(OP_TICK, 8'h00, 9'd0);
  endtask

  task automatic test_long_haul();
    set_config(8'hFF, 8'hFF, 16'hFFFF);
    send_frame(9'd256, FRAME_GOOD, 0);
    send_frame(9'h1FF, FRAME_BAD_CRC, 0);
    set_config(8'hFF, 8'hFF, 16'd40);
    send_req(OP_START, 8'h00, 9'd257);
    send_req(OP_BYTE, 8'hFF, 9'd0);
    repeat (41) send_req(OP_TICK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
  endtask

  task automatic test_random(int unsigned target, int unsigned tick_pct);
    int unsigned stop_at;
    int unsigned pick;
    logic [8:0]  len;
    stop_at = live_items + target;
    while (live_items < stop_at) begin
      pick = $urandom_range(0, 99);
      len  = 9'(($urandom_range(0, 99) < 85) ? $urandom_range(4, 16) :
                ($urandom_range(0, 99) < 50) ? $urandom_range(0, 3) :
                ($urandom_range(0, 99) < 75) ? $urandom_range(17, 64) :
                $urandom_range(255, 511));
      if (pick < 62) send_frame(len, FRAME_GOOD, tick_pct);
      else if (pick < 68) send_frame(len, FRAME_BAD_ADDR, tick_pct);
      else if (pick < 74) send_frame(len, FRAME_BAD_FUNC, tick_pct);
      else if (pick < 82) send_frame(len, FRAME_BAD_CRC, tick_pct);
      else if (pick < 85) send_frame(len, FRAME_BAD_ALL, tick_pct);
      else if (pick < 91) send_frame(len, FRAME_CUT, tick_pct);
      else if (pick < 93) drain();
      else begin
        repeat ($urandom_range(1, 4)) begin
          send_req(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   9'($urandom_range(0, 511)));
        end
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d bytes %0d",
                 $time, out_status, out_bytes_received);
        error_count++;
      end else begin
        head = pending_verdicts.pop_front();
        if (out_status !== head.status) begin
          $display("%0t: status expected %0d actual %0d", $time, head.status, out_status);
          error_count++;
        end
        if (out_bytes_received !== head.count) begin
          $display("%0t: bytes_received expected %0d actual %0d",
                   $time, head.count, out_bytes_received);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OP_NONE;
    in_data_byte    = '0;
    in_frame_length = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_DEVICE_ADDRESS;
    cfg_wdata       = '0;
    idle_on         = 1'b1;
    error_count     = 0;
    live_items      = 0;
    dev_addr        = DEVICE_ADDRESS_RST;
    func_code       = FUNCTION_CODE_RST;
    tick_limit      = TIMEOUT_TICKS_RST;
    frame_open      = 1'b0;
    rx_count        = '0;
    frame_len       = MIN_FRAME_BYTES;
    tick_count      = '0;
    crc_acc         = CRC_INIT;
    crc_lo          = '0;
    hdr_match       = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_known_crc();
    test_header_and_crc();
    test_ignored_requests();
    test_timeout();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(20, 60)));
    test_random(250, 10);
    set_config(8'h00, 8'hFF, 16'd2);
    test_random(150, 3);
    set_config(8'hFF, 8'h00, 16'hFFFF);
    test_random(250, 30);
    test_long_haul();
    drain();
    idle_on = 1'b0;
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom_range(5, 100)));
    test_random(250, 8);

    drain();
    repeat (6) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/mbrc_pkg.sv
hdl/mbrc_crc_byte.sv
hdl/mbrc_frame_ctrl.sv
hdl/modbus_response_frame_checker.sv
dv/tb_modbus_response_frame_checker.sv
